### hdl/mf3rgb_pkg.sv
package mf3rgb_pkg;

  // Largest frame the line stores are sized for
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Field widths fixed by the interface
  localparam int CH_W   = 8;
  localparam int DATA_W = 3 * CH_W;
  localparam int DIM_W  = 12;

  // Column index into a line store, row counter (runs two rows past the frame
  // while draining), and a common width for position compares
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int CMP_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

  localparam int WIN_SIZE    = 9;
  localparam int RANK_W      = $clog2(WIN_SIZE);
  localparam int MEDIAN_RANK = 4;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Input word kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

endpackage

### hdl/mf3rgb_ram.sv
module mf3rgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/median_filter_3x3_rgb.sv
// 3x3 median filter for an RGB pixel stream, ranked by red. Pixels enter in
// raster order, one word per clock sustained; the block takes a new word in
// every cycle unless a result waits in the output register and the sink does
// not take it. For each interior pixel the output is the whole window pixel
// whose red value is the median of nine (ties go to the earlier pixel in scan
// order, top row first, left to right); pixels on the first or last row or
// column pass through unchanged. Each result lags its input word by
// frame_width+1 positions, so after the last pixel of a frame send
// frame_width+1 flush words (tuser high) to drain it; a flush sent earlier is
// dropped, and a pixel sent after the frame is full counts as a flush. The
// word that causes a result enters the window stage with its line store read;
// the window update and rank select then feed the output register. Two line
// stores of MAX_WIDTH entries hold the previous rows; they need no clearing
// after reset. Write frame_width / frame_height only while the block is idle:
// a write restarts the frame. 0 acts as 1, and values above the maximum
// saturate. m_tlast marks the last pixel of a row, m_tuser the last pixel of
// the frame.
module median_filter_3x3_rgb
  import mf3rgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue
  input  logic              s_tuser,   // [0] opcode
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic              m_tlast,   // row_end
  output logic              m_tuser,   // [0] frame_end
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  // Frame geometry, held already clamped to [1, MAX]
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [DIM_W-1:0] cfg_clamp_w;
  logic [DIM_W-1:0] cfg_clamp_h;

  // Input position
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col_next;
  logic [ROW_W-1:0] pos_row_next;

  // Front end: position math on the incoming word
  logic [CMP_W-1:0] wx, hx, colx, rowx, cx, col_inc, qr, qc;
  logic             in_pixels;
  logic             accept;
  logic             drop;
  logic             step;
  logic             has_res0;
  logic             interior0;
  logic             rend0;
  logic             fend0;
  logic [COL_W-1:0] c0;
  pixel_t           px0;

  // Window stage
  logic             v1;
  logic             adv1;
  pixel_t           px1;
  logic [COL_W-1:0] c1;
  logic             res1;
  logic             interior1;
  logic             rend1;
  logic             fend1;
  logic             fwd1;
  pixel_t           fwd_up1;
  pixel_t           fwd_mid1;
  pixel_t           ram_up_q;
  pixel_t           ram_mid_q;
  pixel_t           up_eff;
  pixel_t           mid_eff;

  pixel_t           win [WIN_SIZE];
  pixel_t           win_next [WIN_SIZE];
  pixel_t           median;
  pixel_t           result;

  // Output register
  pixel_t           out_px;

  // ---------------------------------------------------------------------------
  // Configuration: clamp on write, restart the frame
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamp_w = DIM_W'(1);
    end else if ((CMP_W)'(cfg_data) > (CMP_W)'(MAX_WIDTH)) begin
      cfg_clamp_w = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_clamp_w = cfg_data;
    end
    if (cfg_data == '0) begin
      cfg_clamp_h = DIM_W'(1);
    end else if ((CMP_W)'(cfg_data) > (CMP_W)'(MAX_HEIGHT)) begin
      cfg_clamp_h = DIM_W'(MAX_HEIGHT);
    end else begin
      cfg_clamp_h = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_clamp_w;
        CFG_FRAME_HEIGHT: frame_height <= cfg_clamp_h;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: where the incoming word lands and which result it releases
  // ---------------------------------------------------------------------------
  assign wx   = CMP_W'(frame_width);
  assign hx   = CMP_W'(frame_height);
  assign colx = CMP_W'(pos_col);
  assign rowx = CMP_W'(pos_row);

  assign in_pixels = rowx < hx;
  assign accept    = s_tvalid && s_tready;
  // flush words before the frame is complete do nothing
  assign drop      = (s_tuser == OP_FLUSH) && in_pixels;
  assign step      = accept && !drop;

  assign cx      = (colx >= wx) ? (wx - CMP_W'(1)) : colx;
  assign c0      = cx[COL_W-1:0];
  assign col_inc = cx + CMP_W'(1);

  always_comb begin
    // the result leaving now sits one row and one column behind
    if (cx != '0) begin
      has_res0 = rowx >= CMP_W'(1);
      qr       = rowx - CMP_W'(1);
      qc       = cx - CMP_W'(1);
    end else begin
      has_res0 = rowx >= CMP_W'(2);
      qr       = rowx - CMP_W'(2);
      qc       = wx - CMP_W'(1);
    end
    interior0 = (qr >= CMP_W'(1)) && (qr + CMP_W'(2) <= hx) &&
                (qc >= CMP_W'(1)) && (qc + CMP_W'(2) <= wx);
    rend0     = qc == (wx - CMP_W'(1));
    fend0     = rend0 && (qr == (hx - CMP_W'(1)));
  end

  always_comb begin
    if (in_pixels) begin
      px0.red   = s_tdata[CH_W-1:0];
      px0.green = s_tdata[2*CH_W-1:CH_W];
      px0.blue  = s_tdata[3*CH_W-1:2*CH_W];
    end else begin
      px0 = '0;
    end
  end

  always_comb begin
    if (has_res0 && fend0) begin
      pos_col_next = '0;
      pos_row_next = '0;
    end else if (col_inc >= wx) begin
      pos_col_next = '0;
      pos_row_next = pos_row + ROW_W'(1);
    end else begin
      pos_col_next = col_inc[COL_W-1:0];
      pos_row_next = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos_col <= '0;
      pos_row <= '0;
    end else if (step) begin
      pos_col <= pos_col_next;
      pos_row <= pos_row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read when a kept word is accepted, write back when the word leaves the window
  // stage. A write to the same column in the same cycle is forwarded.
  // ---------------------------------------------------------------------------
  mf3rgb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk   (clk),
    .we    (adv1),
    .waddr (c1),
    .wdata (mid_eff),
    .re    (step),
    .raddr (c0),
    .rdata (ram_up_q)
  );

  mf3rgb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk   (clk),
    .we    (adv1),
    .waddr (c1),
    .wdata (px1),
    .re    (step),
    .raddr (c0),
    .rdata (ram_mid_q)
  );

  assign up_eff  = fwd1 ? fwd_up1  : ram_up_q;
  assign mid_eff = fwd1 ? fwd_mid1 : ram_mid_q;

  // ---------------------------------------------------------------------------
  // Window stage: advance when its result, if any, can enter the output
  // register. Words without a result slide the window without loading the output.
  // ---------------------------------------------------------------------------
  assign adv1     = v1 && (!res1 || !m_tvalid || m_tready);
  assign s_tready = !v1 || adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (step) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      px1       <= px0;
      c1        <= c0;
      res1      <= has_res0;
      interior1 <= interior0;
      rend1     <= rend0;
      fend1     <= fend0;
      fwd1      <= adv1 && (c1 == c0);
      fwd_up1   <= mid_eff;
      fwd_mid1  <= px1;
    end
  end

  // Slide the window one column and take the new right column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[3*k]     = win[3*k+1];
      win_next[3*k + 1] = win[3*k+2];
    end
    win_next[2] = up_eff;
    win_next[5] = mid_eff;
    win_next[8] = px1;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        win[k] <= '0;
      end
    end else if (adv1) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

  // Rank select: pixel i ranks by how many pixels order before it; equal red
  // values order by scan position. Exactly one pixel has the median rank.
  always_comb begin
    logic [WIN_SIZE-1:0] ahead;
    logic [RANK_W-1:0]   rank;
    median = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      for (int j = 0; j < WIN_SIZE; j++) begin
        ahead[j] = (win_next[j].red < win_next[i].red) ||
                   ((win_next[j].red == win_next[i].red) && (j < i));
      end
      rank = RANK_W'($countones(ahead));
      if (rank == RANK_W'(MEDIAN_RANK)) begin
        median = median | win_next[i];
      end
    end
  end

  assign result = interior1 ? median : win_next[4];

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv1 && res1) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && res1) begin
      out_px  <= result;
      m_tlast <= rend1;
      m_tuser <= fend1;
    end
  end

  assign m_tdata = {out_px.blue, out_px.green, out_px.red};

endmodule

### hdl/mf3rgb_chk.sv
module mf3rgb_chk
  import mf3rgb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                 $stable(m_tlast) && $stable(m_tuser)))
    else $error("output word changed while stalled");

  // the last pixel of a frame is also the last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end without row end");

  // with the output register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind median_filter_3x3_rgb mf3rgb_chk u_mf3rgb_chk (.*);

### sim/tb_median_filter_3x3_rgb.sv
`timescale 1ns / 100ps

module tb_median_filter_3x3_rgb
  import mf3rgb_pkg::*;
;

  // Longest stretch with no word moved on any port before the run is called hung
  localparam int unsigned QUIET_LIMIT  = 500;
  // Cycles to let the pipeline empty before a register write or the end check
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TAIL         = 12;
  localparam int unsigned RANDOM_WORDS = 1000;
  localparam int unsigned CALM_AFTER   = 850;
  localparam int unsigned PLAN_ROWS    = 22;

  // One filtered pixel as it leaves the block
  typedef struct packed {
    pixel_t px;
    logic   row_end;
    logic   frame_end;
  } filt_out_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // One line of the directed plan: a register write or an input word. Where
  // typed is set, want is the result that this word releases.
  typedef struct packed {
    row_kind_e        kind;
    logic             reg_sel;
    logic [DIM_W-1:0] value;
    logic             op;
    pixel_t           px;
    logic             typed;
    filt_out_t        want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
  logic              s_tuser = 1'b0; // [0] opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  logic              m_tlast;        // row_end
  logic              m_tuser;        // [0] frame_end
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [DIM_W-1:0]  cfg_data = '0;

  median_filter_3x3_rgb u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the filter: register copies, the two line stores, the 3x3
  // window and the raster position. Stepped once per accepted input word.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] frame_w_raw = 12'd640;
  logic [DIM_W-1:0] frame_h_raw = 12'd480;
  pixel_t           rows_above [MAX_WIDTH];
  pixel_t           rows_mid   [MAX_WIDTH];
  pixel_t           win        [WIN_SIZE];
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;

  // Filtered pixels still owed by the block, oldest first
  filt_out_t        due_pixels [$];

  int unsigned      fail_count = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      sink_hold = 0;
  bit               gaps_on = 1'b1;

  // Zero acts as one, anything past the line store size saturates
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw,
                                          input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Rank by red only; equal reds rank in scan order, so the earlier pixel of
  // the window (top row first, left to right) sits lower.
  function automatic pixel_t rank_select();
    int unsigned rank;
    for (int i = 0; i < WIN_SIZE; i++) begin
      rank = 0;
      for (int j = 0; j < WIN_SIZE; j++) begin
        if (win[j].red < win[i].red || (win[j].red == win[i].red && j < i)) rank++;
      end
      if (rank == MEDIAN_RANK) return win[i];
    end
    return win[MEDIAN_RANK];
  endfunction

  task automatic median_step(input logic op, input pixel_t px_in,
                             output bit made, output filt_out_t res);
    int unsigned w, h, c, r, qr, qc;
    bit          in_frame, inner;
    pixel_t      px, up, mid;
    made = 1'b0;
    res  = '0;
    w = eff_dim(frame_w_raw, MAX_WIDTH);
    h = eff_dim(frame_h_raw, MAX_HEIGHT);
    in_frame = row_pos < h;
    // Drop a flush that arrives while the frame still takes pixels
    if (op == OP_FLUSH && in_frame) return;
    // Past the last row every word drains as a zero pixel
    px = in_frame ? px_in : pixel_t'('0);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = row_pos;
    up  = rows_above[c];
    mid = rows_mid[c];
    rows_above[c] = mid;
    rows_mid[c]   = px;
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    // The window centre trails the input by one row and one column
    if (c >= 1) begin
      if (r < 1) return;
      qr = r - 1;
      qc = c - 1;
    end else begin
      if (r < 2) return;
      qr = r - 2;
      qc = w - 1;
    end
    inner = qr >= 1 && qr + 2 <= h && qc >= 1 && qc + 2 <= w;
    res.px        = inner ? rank_select() : win[4];
    res.row_end   = (qc == w - 1);
    res.frame_end = res.row_end && (qr == h - 1);
    made = 1'b1;
    if (res.frame_end) begin
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic pixel_t rand_pixel(input bit ties);
    pixel_t px;
    // Squeeze red into a narrow band now and then so the window holds equal reds
    px.red   = ties ? 8'(8'h7e + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue  = 8'($urandom_range(0, 255));
    return px;
  endfunction

  // Offer one word, hold it until taken, then advance the shadow. A typed
  // expectation replaces the predicted one for that word.
  task automatic send_word(input logic op, input pixel_t px, input bit typed,
                           input filt_out_t want);
    bit        made;
    filt_out_t res;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {px.blue, px.green, px.red};
    do @(posedge clk); while (!s_tready);
    median_step(op, px, made, res);
    if (typed) due_pixels.push_back(want);
    else if (made) due_pixels.push_back(res);
  endtask

  // Write a register only once every owed pixel is out and the pipeline has
  // had time to settle; the write restarts the frame.
  task automatic write_reg(input logic sel, input logic [DIM_W-1:0] value);
    s_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_FRAME_WIDTH) frame_w_raw = value;
    else frame_h_raw = value;
    foreach (win[i]) win[i] = '0;
    row_pos = 0;
    col_pos = 0;
  endtask

  // One frame at the current size followed by its drain. A noisy frame slips
  // in early flushes (dropped by the block) and sometimes drains with pixels;
  // a broken frame stops at a random point.
  task automatic send_frame(input bit noisy, input bit broken, input bit ties,
                            output int unsigned words);
    int unsigned w, n_px, total;
    logic        op;
    w     = eff_dim(frame_w_raw, MAX_WIDTH);
    n_px  = w * eff_dim(frame_h_raw, MAX_HEIGHT);
    total = broken ? $urandom_range(0, n_px + w) : n_px + w + 1;
    words = total;
    for (int unsigned k = 0; k < total; k++) begin
      if (k < n_px) begin
        if (noisy && $urandom_range(0, 15) == 0)
          send_word(OP_FLUSH, rand_pixel(ties), 1'b0, '0);
        send_word(OP_PIXEL, rand_pixel(ties), 1'b0, '0);
      end else begin
        op = (noisy && $urandom_range(0, 7) == 0) ? OP_PIXEL : OP_FLUSH;
        send_word(op, rand_pixel(ties), 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan. First a 3x3 frame: the single interior pixel sees five
  // equal reds, so the pick falls to the second of them in scan order. Every
  // border pixel passes through and is typed in. Then width written as zero,
  // which acts as one: a single column, all border.
  // ---------------------------------------------------------------------------
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_CFG,  CFG_FRAME_WIDTH,  12'd3, OP_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_CFG,  CFG_FRAME_HEIGHT, 12'd3, OP_PIXEL, 24'h000000, 1'b0, '0},
    // flush ahead of any pixel: dropped
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'hffffff, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h801122, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h803344, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h805566, 1'b1,
      '{24'h000000, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h7f7788, 1'b1,
      '{24'hffffff, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h8099aa, 1'b1,
      '{24'h801122, 1'b1, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h80bbcc, 1'b1,
      '{24'h803344, 1'b0, 1'b0}},
    // last pixel releases the interior result: left to the shadow
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h01ddee, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b1,
      '{24'h7f7788, 1'b1, 1'b0}},
    // pixel once the frame is full: drains like a flush, value discarded
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h5a5a5a, 1'b1,
      '{24'h8099aa, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b1,
      '{24'h80bbcc, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b1,
      '{24'h01ddee, 1'b1, 1'b1}},
    '{ROW_CFG,  CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h123456, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'habcdef, 1'b0, '0},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_PIXEL, 24'h0ff03c, 1'b1,
      '{24'h123456, 1'b1, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b1,
      '{24'habcdef, 1'b1, 1'b0}},
    '{ROW_WORD, CFG_FRAME_WIDTH,  12'd0, OP_FLUSH, 24'h000000, 1'b1,
      '{24'h0ff03c, 1'b1, 1'b1}}
  };

  initial begin
    int unsigned random_words, frames, words;
    int unsigned pick;
    random_words = 0;
    foreach (rows_above[i]) begin
      rows_above[i] = '0;
      rows_mid[i]   = '0;
    end
    foreach (win[i]) win[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].reg_sel, plan[i].value);
      else send_word(plan[i].op, plan[i].px, plan[i].typed, plan[i].want);
    end

    // Random phases: each rewrites one or both registers and sends a few frames
    while (random_words < RANDOM_WORDS) begin
      // Run some phases with no idling at all, and the tail of the run too
      gaps_on = random_words < CALM_AFTER && $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 2);
      if (pick != 1)
        write_reg(CFG_FRAME_WIDTH,
                  ($urandom_range(0, 11) == 0) ? 12'd0 : DIM_W'($urandom_range(1, 8)));
      if (pick != 0)
        write_reg(CFG_FRAME_HEIGHT,
                  ($urandom_range(0, 11) == 0) ? 12'd0 : DIM_W'($urandom_range(1, 6)));
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        send_frame(1'b1, f == frames - 1 && $urandom_range(0, 9) == 0,
                   $urandom_range(0, 2) == 0, words);
        random_words += words;
      end
    end

    // Stop offering, wait out every owed pixel, then give stragglers a chance
    s_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts while gaps are on
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!rst && gaps_on && $urandom_range(0, 5) == 0) begin
      m_tready  <= 1'b0;
      sink_hold <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic flag_result(input string what, input filt_out_t want,
                             input filt_out_t got);
    if (fail_count < 10)
      $display("%0t %s: want %02h/%02h/%02h row_end=%0b frame_end=%0b, got %02h/%02h/%02h row_end=%0b frame_end=%0b",
               $realtime, what, want.px.red, want.px.green, want.px.blue,
               want.row_end, want.frame_end, got.px.red, got.px.green,
               got.px.blue, got.row_end, got.frame_end);
    fail_count++;
  endtask

  // Compare each word taken from the block against the oldest owed pixel
  always @(posedge clk) begin
    filt_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.px.red    = m_tdata[7:0];
      got.px.green  = m_tdata[15:8];
      got.px.blue   = m_tdata[23:16];
      got.row_end   = m_tlast;
      got.frame_end = m_tuser;
      if (due_pixels.size() == 0) begin
        flag_result("unexpected word", '0, got);
      end else begin
        want = due_pixels.pop_front();
        if (got !== want) flag_result("mismatch", want, got);
      end
    end
  end

  // Hang guard: any word moved on either stream or a register write resets it
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### filelist.f
hdl/mf3rgb_pkg.sv
hdl/mf3rgb_ram.sv
hdl/median_filter_3x3_rgb.sv
hdl/mf3rgb_chk.sv
sim/tb_median_filter_3x3_rgb.sv
